### src/grid_explorer_move_selector_unit_macros.svh
// Assertion macros shared by the move selector RTL.
`ifndef GRID_EXPLORER_MOVE_SELECTOR_UNIT_MACROS_SVH
`define GRID_EXPLORER_MOVE_SELECTOR_UNIT_MACROS_SVH

// Condition must never hold outside reset.
`define GEMS_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// Same-cycle implication.
`define GEMS_ASSERT_IMPLIES(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define GEMS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### src/gems_pkg.sv
// Shared types, constants and helpers of the move selector.
`timescale 1ns / 1ps
package gems_pkg;

  localparam int MAX_SIDE_DEF   = 64;
  localparam int MAX_AGENTS_DEF = 16;

  localparam int COORD_IN_W = 6;
  localparam int SLOT_W     = 4;
  localparam int GRID_REG_W = 7;
  localparam int PEN_W      = 10;
  localparam int NEAR_W     = 8;
  localparam int SCORE_W    = 24;
  localparam int OUT_SCORE_W = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 10;
  localparam int VISIT_W    = 8;

  localparam logic signed [SCORE_W-1:0] SAT_HI = SCORE_W'(32767);
  localparam logic signed [SCORE_W-1:0] SAT_LO = -SCORE_W'(32767);
  localparam logic signed [OUT_SCORE_W-1:0] BLOCKED_OUT = 16'sh8000;

  typedef enum logic [1:0] {
    OP_WALL   = 2'd0,
    OP_PLACE  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_CHOOSE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    MV_UP    = 2'd0,
    MV_DOWN  = 2'd1,
    MV_LEFT  = 2'd2,
    MV_RIGHT = 2'd3
  } move_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 4'd0,
    CFG_GRID_HEIGHT = 4'd1,
    CFG_WALLS_EN    = 4'd2,
    CFG_UNVISITED   = 4'd3,
    CFG_REVISIT     = 4'd4,
    CFG_PROXIMITY   = 4'd5,
    CFG_GUIDANCE    = 4'd6,
    CFG_BACKTRACK   = 4'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MAC_HOLD = 2'd0,
    MAC_CLR  = 2'd1,
    MAC_ADD  = 2'd2,
    MAC_SUB  = 2'd3
  } mac_op_t;

  // agent table answer for one probed cell
  typedef struct packed {
    logic              hit;
    logic [NEAR_W-1:0] near_cnt;
  } agent_probe_t;

  function automatic logic signed [1:0] step_dx(input move_t d);
    logic signed [1:0] r;
    case (d)
      MV_LEFT:  r = 2'sb11;
      MV_RIGHT: r = 2'sb01;
      default:  r = 2'sb00;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] step_dy(input move_t d);
    logic signed [1:0] r;
    case (d)
      MV_UP:   r = 2'sb11;
      MV_DOWN: r = 2'sb01;
      default: r = 2'sb00;
    endcase
    return r;
  endfunction

endpackage

### src/gems_agent_table.sv
// Other-agent slots with a registered occupancy and proximity probe.
`timescale 1ns / 1ps
module gems_agent_table #(
  parameter int MAX_AGENTS = gems_pkg::MAX_AGENTS_DEF,
  parameter int XW         = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   wr_en,
  input  logic                                   wr_place,
  input  logic [gems_pkg::SLOT_W-1:0]            wr_slot,
  input  logic [gems_pkg::COORD_IN_W-1:0]        wr_x,
  input  logic [gems_pkg::COORD_IN_W-1:0]        wr_y,
  input  logic signed [XW-1:0]                   probe_x,
  input  logic signed [XW-1:0]                   probe_y,
  output gems_pkg::agent_probe_t                 probe_res
);
  import gems_pkg::*;

  logic                  agent_valid [MAX_AGENTS];
  logic [COORD_IN_W-1:0] agent_x     [MAX_AGENTS];
  logic [COORD_IN_W-1:0] agent_y     [MAX_AGENTS];
  agent_probe_t          probe_c;

  // slot valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_AGENTS; i++) agent_valid[i] <= 1'b0;
    end else if (wr_en) begin
      for (int i = 0; i < MAX_AGENTS; i++) begin
        if (int'(wr_slot) == i) agent_valid[i] <= wr_place;
      end
    end
  end

  // slot positions
  always_ff @(posedge clk) begin
    if (wr_en && wr_place) begin
      for (int i = 0; i < MAX_AGENTS; i++) begin
        if (int'(wr_slot) == i) begin
          agent_x[i] <= wr_x;
          agent_y[i] <= wr_y;
        end
      end
    end
  end

  // Manhattan distance to every slot in parallel
  always_comb begin
    logic signed [XW:0] dx;
    logic signed [XW:0] dy;
    logic        [XW:0] man_dist;
    probe_c = '0;
    for (int i = 0; i < MAX_AGENTS; i++) begin
      dx       = (XW+1)'(probe_x) - $signed((XW+1)'(agent_x[i]));
      dy       = (XW+1)'(probe_y) - $signed((XW+1)'(agent_y[i]));
      man_dist = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
      if (agent_valid[i]) begin
        if (man_dist == '0) probe_c.hit = 1'b1;
        if (man_dist == (XW+1)'(1) || man_dist == (XW+1)'(2)) begin
          probe_c.near_cnt = probe_c.near_cnt + NEAR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    probe_res <= probe_c;
  end

endmodule

### src/gems_mac.sv
// Shared multiply-accumulate unit for move scoring.
`timescale 1ns / 1ps
module gems_mac (
  input  logic                                  clk,
  input  gems_pkg::mac_op_t                     op,
  input  logic [gems_pkg::NEAR_W-1:0]           a,
  input  logic [gems_pkg::PEN_W-1:0]            b,
  output logic signed [gems_pkg::SCORE_W-1:0]   acc
);
  import gems_pkg::*;

  logic [NEAR_W+PEN_W-1:0]    prod;
  logic signed [SCORE_W-1:0]  prod_s;

  assign prod   = a * b;
  assign prod_s = $signed(SCORE_W'(prod));

  always_ff @(posedge clk) begin
    unique case (op)
      MAC_CLR:  acc <= '0;
      MAC_ADD:  acc <= acc + prod_s;
      MAC_SUB:  acc <= acc - prod_s;
      MAC_HOLD: acc <= acc;
      default:  acc <= acc;
    endcase
  end

endmodule

### src/grid_explorer_move_selector_unit.sv
// Top level of the grid explorer move selector: sequencer, cell stores, output register.
//
// Items arrive on the s_axis channel. Opcodes for wall writes and agent slot
// updates give no result. A choose item clears the search marks, counts a
// visit of its own cell, runs a breadth-first search over the cell stores
// and scores the four moves on a shared multiply-accumulate unit; one
// result then leaves on m_axis. CELLS = 4096 at the default side of 64.
// s_axis_tready is high only while the sequencer idles.
// After reset the block sweeps all CELLS entries of the wall, visit and
// search mark stores before it takes an item; configuration writes are
// taken at any time on the cfg channel and should only be issued while idle.
// The result sits in an output register; a stalled receiver holds it, and a
// finished choose waits for that register to drain before it is loaded.
// Cells are stored by row and column bits, so CELLS is the square of the next
// power of two at or above MAX_SIDE.
`timescale 1ns / 1ps
`include "grid_explorer_move_selector_unit_macros.svh"
module grid_explorer_move_selector_unit #(
  parameter int MAX_SIDE   = gems_pkg::MAX_SIDE_DEF,
  parameter int MAX_AGENTS = gems_pkg::MAX_AGENTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [5:0] cell_x, [11:6] cell_y, [15:12] agent_slot, [16] wall_flag
  input  logic [23:0]                          s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [1:0] move, [17:2] score, [18] target_found, [24:19] step_x, [30:25] step_y
  output logic [31:0]                          m_axis_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gems_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gems_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import gems_pkg::*;

  localparam int CW    = $clog2(MAX_SIDE);
  localparam int AW    = 2 * CW;
  localparam int CELLS = 1 << AW;
  localparam int XW    = ((CW > COORD_IN_W) ? CW : COORD_IN_W) + 2;
  localparam int UW    = XW - 1;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_CLR, S_VRD, S_VWR, S_NB, S_NBCHK, S_POP, S_POPD,
    S_TEST, S_TEST2, S_TRC, S_TRCD, S_SCSET, S_SC0, S_SC1, S_SC2, S_SC3,
    S_SC4, S_SCCMP, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [GRID_REG_W-1:0] grid_width, grid_height;
  logic                  walls_enabled;
  logic [PEN_W-1:0]      unvisited_bonus, revisit_penalty, proximity_penalty;
  logic [PEN_W-1:0]      guidance_bonus, backtrack_penalty;

  // input fields
  opcode_t               in_op;
  logic [COORD_IN_W-1:0] in_x, in_y;
  logic [SLOT_W-1:0]     in_slot;
  logic                  in_flag;
  logic                  in_acc;
  logic                  in_store;

  // search and scoring registers
  logic [AW-1:0]         clr_cnt;
  logic signed [XW-1:0]  sx, sy, cx, cy, fx, fy;
  logic                  in_store_q;
  logic                  from_start;
  move_t                 dir;
  logic [AW:0]           head, tail;
  logic [AW-1:0]         trace_idx;
  logic                  found;
  logic [VISIT_W-1:0]    visit_q;
  logic                  cur_blk;
  logic                  best_any, best_blocked;
  logic signed [SCORE_W-1:0] best_acc;
  move_t                 best_move;
  logic [COORD_IN_W-1:0] prev_x, prev_y;
  logic                  has_prev;

  // output register
  logic                  out_valid;
  logic [31:0]           out_data;

  // cell stores
  logic                  wall_mem   [CELLS];
  logic [VISIT_W-1:0]    visit_mem  [CELLS];
  logic                  seen_mem   [CELLS];
  logic [AW-1:0]         parent_mem [CELLS];
  logic [AW-1:0]         queue_mem  [CELLS];

  logic                  wall_we, visit_we, seen_we, qp_we;
  logic [AW-1:0]         wall_wa, visit_wa, seen_wa, visit_ra;
  logic                  wall_wd, seen_wd;
  logic [VISIT_W-1:0]    visit_wd;
  logic                  wall_rd, seen_rd;
  logic [VISIT_W-1:0]    visit_rd;
  logic [AW-1:0]         parent_rd, queue_rd;

  // neighbour of the current cell in direction dir
  logic signed [XW-1:0]  nx_c, ny_c;
  logic [AW-1:0]         n_idx, cur_idx, own_idx;
  logic                  n_on, own_on;
  logic [UW-1:0]         used_w, used_h;

  agent_probe_t          probe_res;
  logic signed [XW-1:0]  probe_x, probe_y;
  mac_op_t               mac_op;
  logic [NEAR_W-1:0]     mac_a;
  logic [PEN_W-1:0]      mac_b;
  logic signed [SCORE_W-1:0] acc;
  logic                  better;
  logic signed [OUT_SCORE_W-1:0] shown;

  function automatic logic on_grid(input logic signed [XW-1:0] x,
                                   input logic signed [XW-1:0] y,
                                   input logic [UW-1:0] w,
                                   input logic [UW-1:0] h);
    return !x[XW-1] && !y[XW-1] && (x[UW-1:0] < w) && (y[UW-1:0] < h);
  endfunction

  function automatic logic [AW-1:0] cell_of(input logic signed [XW-1:0] x,
                                            input logic signed [XW-1:0] y);
    return {y[CW-1:0], x[CW-1:0]};
  endfunction

  assign in_op   = opcode_t'(s_axis_tuser);
  assign in_x    = s_axis_tdata[5:0];
  assign in_y    = s_axis_tdata[11:6];
  assign in_slot = s_axis_tdata[15:12];
  assign in_flag = s_axis_tdata[16];
  assign s_axis_tready = (state == S_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_store = (UW'(in_x) < UW'(MAX_SIDE)) && (UW'(in_y) < UW'(MAX_SIDE));
  assign cfg_ready = 1'b1;

  assign used_w = (UW'(grid_width)  > UW'(MAX_SIDE)) ? UW'(MAX_SIDE) : UW'(grid_width);
  assign used_h = (UW'(grid_height) > UW'(MAX_SIDE)) ? UW'(MAX_SIDE) : UW'(grid_height);

  assign nx_c    = cx + XW'(step_dx(dir));
  assign ny_c    = cy + XW'(step_dy(dir));
  assign n_idx   = cell_of(nx_c, ny_c);
  assign n_on    = on_grid(nx_c, ny_c, used_w, used_h);
  assign cur_idx = cell_of(cx, cy);
  assign own_idx = cell_of(sx, sy);
  assign own_on  = on_grid(sx, sy, used_w, used_h);

  // store port control
  always_comb begin
    wall_we  = 1'b0;
    wall_wa  = n_idx;
    wall_wd  = 1'b0;
    visit_we = 1'b0;
    visit_wa = own_idx;
    visit_wd = '0;
    seen_we  = 1'b0;
    seen_wa  = n_idx;
    seen_wd  = 1'b0;
    qp_we    = 1'b0;
    visit_ra = n_idx;
    unique case (state)
      S_INIT: begin
        wall_we  = 1'b1;
        wall_wa  = clr_cnt;
        visit_we = 1'b1;
        visit_wa = clr_cnt;
        seen_we  = 1'b1;
        seen_wa  = clr_cnt;
      end
      S_IDLE: begin
        wall_we = in_acc && (in_op == OP_WALL) && in_store;
        wall_wa = cell_of(XW'(in_x), XW'(in_y));
        wall_wd = in_flag;
      end
      S_CLR: begin
        seen_we = 1'b1;
        seen_wa = clr_cnt;
      end
      S_VRD: visit_ra = own_idx;
      S_VWR: begin
        visit_we = in_store_q;
        visit_wd = (visit_rd != '1) ? visit_rd + VISIT_W'(1) : visit_rd;
        seen_we  = own_on;
        seen_wa  = own_idx;
        seen_wd  = 1'b1;
      end
      S_NBCHK: begin
        if (!((walls_enabled && wall_rd) || seen_rd)) begin
          seen_we = 1'b1;
          seen_wd = 1'b1;
          qp_we   = 1'b1;
        end
      end
      S_TEST: visit_ra = cur_idx;
      default: ;
    endcase
  end

  // wall map
  always_ff @(posedge clk) begin
    if (wall_we) wall_mem[wall_wa] <= wall_wd;
    wall_rd <= wall_mem[n_idx];
  end

  // visit counts
  always_ff @(posedge clk) begin
    if (visit_we) visit_mem[visit_wa] <= visit_wd;
    visit_rd <= visit_mem[visit_ra];
  end

  // search marks
  always_ff @(posedge clk) begin
    if (seen_we) seen_mem[seen_wa] <= seen_wd;
    seen_rd <= seen_mem[n_idx];
  end

  // parent links
  always_ff @(posedge clk) begin
    if (qp_we) parent_mem[n_idx] <= from_start ? n_idx : cur_idx;
    parent_rd <= parent_mem[trace_idx];
  end

  // search queue
  always_ff @(posedge clk) begin
    if (qp_we) queue_mem[tail[AW-1:0]] <= n_idx;
    queue_rd <= queue_mem[head[AW-1:0]];
  end

  assign probe_x = (state == S_TEST) ? cx : nx_c;
  assign probe_y = (state == S_TEST) ? cy : ny_c;

  gems_agent_table #(
    .MAX_AGENTS (MAX_AGENTS),
    .XW         (XW)
  ) u_agents (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (in_acc && (in_op == OP_PLACE || in_op == OP_CLEAR)),
    .wr_place  (in_op == OP_PLACE),
    .wr_slot   (in_slot),
    .wr_x      (in_x),
    .wr_y      (in_y),
    .probe_x   (probe_x),
    .probe_y   (probe_y),
    .probe_res (probe_res)
  );

  // score terms fed to the shared MAC
  always_comb begin
    mac_op = MAC_HOLD;
    mac_a  = NEAR_W'(1);
    mac_b  = '0;
    unique case (state)
      S_SC0: mac_op = MAC_CLR;
      S_SC1: begin
        mac_op = MAC_SUB;
        mac_a  = probe_res.near_cnt;
        mac_b  = proximity_penalty;
      end
      S_SC2: begin
        if (visit_q == '0) begin
          mac_op = MAC_ADD;
          mac_b  = unvisited_bonus;
        end else begin
          mac_op = MAC_SUB;
          mac_a  = NEAR_W'(visit_q);
          mac_b  = revisit_penalty;
        end
      end
      S_SC3: begin
        if (found && nx_c == fx && ny_c == fy) begin
          mac_op = MAC_ADD;
          mac_b  = guidance_bonus;
        end
      end
      S_SC4: begin
        if (has_prev && nx_c == XW'(prev_x) && ny_c == XW'(prev_y)) begin
          mac_op = MAC_SUB;
          mac_b  = backtrack_penalty;
        end
      end
      default: ;
    endcase
  end

  gems_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  assign better = !best_any || (best_blocked && !cur_blk) ||
                  (!best_blocked && !cur_blk && acc > best_acc);

  // saturate the winning score
  always_comb begin
    if (best_blocked)        shown = BLOCKED_OUT;
    else if (best_acc > SAT_HI) shown = SAT_HI[OUT_SCORE_W-1:0];
    else if (best_acc < SAT_LO) shown = SAT_LO[OUT_SCORE_W-1:0];
    else                     shown = best_acc[OUT_SCORE_W-1:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_INIT;
      clr_cnt           <= '0;
      out_valid         <= 1'b0;
      has_prev          <= 1'b0;
      prev_x            <= '0;
      prev_y            <= '0;
      grid_width        <= GRID_REG_W'(64);
      grid_height       <= GRID_REG_W'(64);
      walls_enabled     <= 1'b1;
      unvisited_bonus   <= PEN_W'(100);
      revisit_penalty   <= PEN_W'(10);
      proximity_penalty <= PEN_W'(50);
      guidance_bonus    <= PEN_W'(30);
      backtrack_penalty <= PEN_W'(20);
    end else begin
      // register writes
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_GRID_WIDTH:  grid_width        <= cfg_data[GRID_REG_W-1:0];
          CFG_GRID_HEIGHT: grid_height       <= cfg_data[GRID_REG_W-1:0];
          CFG_WALLS_EN:    walls_enabled     <= cfg_data[0];
          CFG_UNVISITED:   unvisited_bonus   <= cfg_data;
          CFG_REVISIT:     revisit_penalty   <= cfg_data;
          CFG_PROXIMITY:   proximity_penalty <= cfg_data;
          CFG_GUIDANCE:    guidance_bonus    <= cfg_data;
          CFG_BACKTRACK:   backtrack_penalty <= cfg_data;
          default: ;
        endcase
      end

      // output beat taken; the output state reloads the register itself
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) out_valid <= 1'b0;

      unique case (state)
        S_INIT: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(CELLS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc && in_op == OP_CHOOSE) begin
            sx         <= XW'(in_x);
            sy         <= XW'(in_y);
            in_store_q <= in_store;
            clr_cnt    <= '0;
            state      <= S_CLR;
          end
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(CELLS - 1)) state <= S_VRD;
        end
        S_VRD: state <= S_VWR;
        S_VWR: begin
          cx         <= sx;
          cy         <= sy;
          from_start <= 1'b1;
          dir        <= MV_UP;
          head       <= '0;
          tail       <= '0;
          state      <= S_NB;
        end
        S_NB: begin
          if (n_on) begin
            state <= S_NBCHK;
          end else if (dir == MV_RIGHT) begin
            state <= S_POP;
          end else begin
            dir <= move_t'(dir + 2'd1);
          end
        end
        S_NBCHK: begin
          if (qp_we) tail <= tail + (AW+1)'(1);
          if (dir == MV_RIGHT) begin
            state <= S_POP;
          end else begin
            dir   <= move_t'(dir + 2'd1);
            state <= S_NB;
          end
        end
        S_POP: begin
          if (head == tail) begin
            fx    <= sx;
            fy    <= sy;
            found <= 1'b0;
            state <= S_SCSET;
          end else begin
            head  <= head + (AW+1)'(1);
            state <= S_POPD;
          end
        end
        S_POPD: begin
          cx    <= XW'(queue_rd[CW-1:0]);
          cy    <= XW'(queue_rd[AW-1:CW]);
          state <= S_TEST;
        end
        S_TEST: state <= S_TEST2;
        S_TEST2: begin
          if (visit_rd == '0 && !probe_res.hit) begin
            trace_idx <= cur_idx;
            state     <= S_TRC;
          end else begin
            from_start <= 1'b0;
            dir        <= MV_UP;
            state      <= S_NB;
          end
        end
        S_TRC: state <= S_TRCD;
        S_TRCD: begin
          if (parent_rd == trace_idx) begin
            fx    <= XW'(trace_idx[CW-1:0]);
            fy    <= XW'(trace_idx[AW-1:CW]);
            found <= 1'b1;
            state <= S_SCSET;
          end else begin
            trace_idx <= parent_rd;
            state     <= S_TRC;
          end
        end
        S_SCSET: begin
          cx       <= sx;
          cy       <= sy;
          dir      <= MV_UP;
          best_any <= 1'b0;
          state    <= S_SC0;
        end
        S_SC0: begin
          cur_blk <= !n_on;
          state   <= n_on ? S_SC1 : S_SCCMP;
        end
        S_SC1: begin
          visit_q <= visit_rd;
          if ((walls_enabled && wall_rd) || probe_res.hit) begin
            cur_blk <= 1'b1;
            state   <= S_SCCMP;
          end else begin
            state <= S_SC2;
          end
        end
        S_SC2: state <= S_SC3;
        S_SC3: state <= S_SC4;
        S_SC4: state <= S_SCCMP;
        S_SCCMP: begin
          if (better) begin
            best_any     <= 1'b1;
            best_blocked <= cur_blk;
            best_acc     <= acc;
            best_move    <= dir;
          end
          if (dir == MV_RIGHT) begin
            state <= S_OUT;
          end else begin
            dir   <= move_t'(dir + 2'd1);
            state <= S_SC0;
          end
        end
        S_OUT: begin
          if (!out_valid || m_axis_tready) begin
            out_valid <= 1'b1;
            out_data  <= {1'b0, fy[COORD_IN_W-1:0], fx[COORD_IN_W-1:0], found,
                          shown, best_move};
            prev_x    <= sx[COORD_IN_W-1:0];
            prev_y    <= sy[COORD_IN_W-1:0];
            has_prev  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // checks
  `GEMS_ASSERT_NEVER(a_head_past_tail, (head > tail) && state != S_INIT && state != S_IDLE && state != S_CLR && state != S_VRD && state != S_VWR, "queue head passed tail")
  `GEMS_ASSERT_NEXT(a_choose_starts, in_acc && in_op == OP_CHOOSE, state == S_CLR, "choose did not start clearing")
  `GEMS_ASSERT_IMPLIES(a_load_from_out, $rose(m_axis_tvalid), $past(state == S_OUT), "result loaded outside output state")

endmodule

### bench/tb_grid_explorer_move_selector_unit.sv
// Self-checking testbench for the grid explorer move selector: directed and random streams.
`timescale 1ns / 1ps
module tb_grid_explorer_move_selector_unit;
  import gems_pkg::*;

  localparam int SIDE  = 64;
  localparam int CELLS = SIDE * SIDE;
  localparam int SLOTS = 16;
  localparam int SETTLE = 20;

  typedef struct {
    move_t              mv;
    logic signed [15:0] score;
    logic               found;
    logic [5:0]         sx;
    logic [5:0]         sy;
  } move_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  grid_explorer_move_selector_unit i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------- predictor state ----------------
  int unsigned grid_w, grid_h, walls_on;
  int unsigned bonus_new, pen_revisit, pen_near, bonus_guide, pen_back;
  bit          wall_cell [CELLS];
  int unsigned visits    [CELLS];
  bit          seen      [CELLS];
  int unsigned parent    [CELLS];
  int unsigned bfs_queue [CELLS];
  logic [12:0] agent_tab [SLOTS];  // [12] valid, [11:6] y, [5:0] x
  int          last_x, last_y;
  bit          last_ok;

  move_result_t pending_moves[$];
  int errors = 0, items_sent = 0, results_seen = 0, chooses = 0, phases = 0;
  bit no_gaps = 1'b0;
  bit stall_req = 1'b0;
  int walk_x = 0, walk_y = 0;

  function automatic int eff(int unsigned v);
    return (v > SIDE) ? SIDE : int'(v);
  endfunction

  function automatic bit in_grid(int x, int y);
    return x >= 0 && y >= 0 && x < eff(grid_w) && y < eff(grid_h);
  endfunction

  function automatic bit wall_at(int unsigned idx);
    return walls_on != 0 && wall_cell[idx % CELLS];
  endfunction

  function automatic bit agent_at(int x, int y);
    for (int i = 0; i < SLOTS; i++)
      if (agent_tab[i][12] && int'(agent_tab[i][5:0]) == x && int'(agent_tab[i][11:6]) == y)
        return 1'b1;
    return 1'b0;
  endfunction

  task automatic grow(input int cx, input int cy, input bit from_start,
                      input int unsigned from, inout int unsigned tail);
    int nx, ny;
    int unsigned idx;
    for (int d = 0; d < 4; d++) begin
      nx = cx + int'(step_dx(move_t'(d)));
      ny = cy + int'(step_dy(move_t'(d)));
      if (!in_grid(nx, ny)) continue;
      idx = ny * SIDE + nx;
      if (wall_at(idx) || seen[idx]) continue;
      if (tail >= CELLS) return;
      seen[idx] = 1'b1;
      parent[idx] = from_start ? idx : from;
      bfs_queue[tail] = idx;
      tail++;
    end
  endtask

  // breadth-first search for the nearest unvisited free cell
  task automatic find_first_step(input int sx, input int sy, output bit found,
                                 output int fx, output int fy);
    int unsigned head, tail, cur, t, p;
    head = 0;
    tail = 0;
    found = 1'b0;
    fx = sx;
    fy = sy;
    for (int i = 0; i < CELLS; i++) seen[i] = 1'b0;
    if (in_grid(sx, sy)) seen[sy * SIDE + sx] = 1'b1;
    grow(sx, sy, 1'b1, 0, tail);
    while (head < tail) begin
      cur = bfs_queue[head] % CELLS;
      head++;
      if (visits[cur] == 0 && !agent_at(cur % SIDE, cur / SIDE)) begin
        t = cur;
        for (int n = 0; n < CELLS; n++) begin
          p = parent[t] % CELLS;
          if (p == t) break;
          t = p;
        end
        fx = t % SIDE;
        fy = t / SIDE;
        found = 1'b1;
        return;
      end
      grow(cur % SIDE, cur / SIDE, 1'b0, cur, tail);
    end
  endtask

  // score of one move; returns 1 in blocked when the move is impossible
  function automatic int rate_move(int nx, int ny, bit found, int fx, int fy,
                                   output bit blocked);
    int s, dx, dy, man_dist;
    int unsigned idx;
    blocked = 1'b1;
    s = 0;
    if (!in_grid(nx, ny)) return 0;
    idx = ny * SIDE + nx;
    if (wall_at(idx)) return 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!agent_tab[i][12]) continue;
      dx = nx - int'(agent_tab[i][5:0]);
      dy = ny - int'(agent_tab[i][11:6]);
      man_dist = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
      if (man_dist == 0) return 0;
      if (man_dist <= 2) s -= int'(pen_near);
    end
    if (visits[idx] == 0) s += int'(bonus_new);
    else s -= int'(visits[idx]) * int'(pen_revisit);
    if (found && nx == fx && ny == fy) s += int'(bonus_guide);
    if (last_ok && nx == last_x && ny == last_y) s -= int'(pen_back);
    blocked = 1'b0;
    return s;
  endfunction

  // apply one accepted item to the predictor state
  task automatic apply_item(input opcode_t op, input int x, input int y,
                            input int slot, input bit flag);
    move_result_t r;
    bit found, blk, any;
    int fx, fy, s, best, best_d;
    case (op)
      OP_WALL:  wall_cell[y * SIDE + x] = flag;
      OP_PLACE: agent_tab[slot] = {1'b1, 6'(y), 6'(x)};
      OP_CLEAR: agent_tab[slot] = '0;
      OP_CHOOSE: begin
        if (visits[y * SIDE + x] < 255) visits[y * SIDE + x]++;
        find_first_step(x, y, found, fx, fy);
        any = 1'b0;
        best = 0;
        best_d = 0;
        for (int d = 0; d < 4; d++) begin
          s = rate_move(x + int'(step_dx(move_t'(d))), y + int'(step_dy(move_t'(d))),
                        found, fx, fy, blk);
          if (!blk && (!any || s > best)) begin
            any = 1'b1;
            best = s;
            best_d = d;
          end
        end
        r.mv = move_t'(best_d);
        if (!any) r.score = BLOCKED_OUT;
        else if (best > 32767) r.score = 16'sd32767;
        else if (best < -32767) r.score = -16'sd32767;
        else r.score = 16'(best);
        r.found = found;
        r.sx = 6'(fx);
        r.sy = 6'(fy);
        pending_moves.push_back(r);
        last_x = x;
        last_y = y;
        last_ok = 1'b1;
        chooses++;
        // follow the predicted move when it is possible
        if (any) begin
          walk_x = (x + int'(step_dx(r.mv))) & 63;
          walk_y = (y + int'(step_dy(r.mv))) & 63;
        end else begin
          walk_x = x;
          walk_y = y;
        end
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // one input beat; entered just after a rising edge, leaves tvalid to the next caller
  task automatic send_item(input opcode_t op, input int x, input int y,
                           input int slot, input bit flag);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, flag, 4'(slot), 6'(y), 6'(x)};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    apply_item(op, x, y, slot, flag);
  endtask

  task automatic choose_at(input int x, input int y);
    send_item(OP_CHOOSE, x, y, $urandom_range(0, 15), $urandom_range(0, 1));
  endtask

  // register write, only once the block has drained and idles
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'(val);
    s_axis_tvalid <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_GRID_WIDTH:  grid_w      = v[6:0];
      CFG_GRID_HEIGHT: grid_h      = v[6:0];
      CFG_WALLS_EN:    walls_on    = v[0];
      CFG_UNVISITED:   bonus_new   = v;
      CFG_REVISIT:     pen_revisit = v;
      CFG_PROXIMITY:   pen_near    = v;
      CFG_GUIDANCE:    bonus_guide = v;
      CFG_BACKTRACK:   pen_back    = v;
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    errors++;
  endtask

  // ---------------- result checking ----------------
  always @(posedge clk) begin : result_check
    move_result_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_moves.size() == 0) begin
        report_mismatch("unexpected beat, data", m_axis_tdata, 0);
      end else begin
        e = pending_moves.pop_front();
        if (m_axis_tdata[1:0] !== e.mv) report_mismatch("move", m_axis_tdata[1:0], e.mv);
        if (m_axis_tdata[17:2] !== e.score)
          report_mismatch("score", $signed(m_axis_tdata[17:2]), e.score);
        if (m_axis_tdata[18] !== e.found) report_mismatch("target_found", m_axis_tdata[18], e.found);
        if (m_axis_tdata[24:19] !== e.sx) report_mismatch("step_x", m_axis_tdata[24:19], e.sx);
        if (m_axis_tdata[30:25] !== e.sy) report_mismatch("step_y", m_axis_tdata[30:25], e.sy);
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int r;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (15000) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else if (no_gaps) begin
        m_axis_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 19);
        if (r < 12) m_axis_tready <= 1'b1;
        else begin
          m_axis_tready <= 1'b0;
          repeat (r < 18 ? $urandom_range(1, 4) : $urandom_range(20, 80)) @(posedge clk);
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_defaults();
    // fresh map at full size: corners and the far edge
    choose_at(0, 0);
    choose_at(63, 63);
    choose_at(0, 0);
  endtask

  task automatic test_all_blocked();
    write_reg(CFG_GRID_WIDTH, 1);
    write_reg(CFG_GRID_HEIGHT, 1);
    choose_at(0, 0);
    write_reg(CFG_GRID_WIDTH, 0);
    choose_at(0, 0);
    // index beyond the register list is ignored
    write_reg(4'(8 + $urandom_range(0, 7)), $urandom_range(0, 1023));
  endtask

  task automatic test_walls_agents();
    write_reg(CFG_GRID_WIDTH, 4);
    write_reg(CFG_GRID_HEIGHT, 4);
    write_reg(CFG_WALLS_EN, 1);
    send_item(OP_WALL, 1, 2, 0, 1'b1);
    send_item(OP_WALL, 2, 1, 0, 1'b1);
    send_item(OP_PLACE, 3, 2, 15, 1'b0);
    send_item(OP_PLACE, 9, 9, 0, 1'b0);   // agent off the grid
    choose_at(2, 2);                      // start next to walls and an agent
    send_item(OP_WALL, 2, 2, 0, 1'b1);
    choose_at(2, 2);                      // start on a wall
    choose_at(5, 1);                      // own position off the grid
    write_reg(CFG_WALLS_EN, 0);
    choose_at(2, 2);
    send_item(OP_CLEAR, 0, 0, 15, 1'b0);
    write_reg(CFG_WALLS_EN, 1);
    send_item(OP_WALL, 2, 2, 0, 1'b0);
  endtask

  task automatic test_saturation();
    // many agents next to a heavily visited cell drive the score below range
    write_reg(CFG_GRID_WIDTH, 2);
    write_reg(CFG_GRID_HEIGHT, 1);
    write_reg(CFG_PROXIMITY, 1023);
    write_reg(CFG_REVISIT, 1023);
    write_reg(CFG_UNVISITED, 1023);
    write_reg(CFG_GUIDANCE, 1023);
    write_reg(CFG_BACKTRACK, 1023);
    for (int i = 0; i < SLOTS; i++) send_item(OP_PLACE, 2, 0, i, 1'b0);
    repeat (17) choose_at(1, 0);
    choose_at(0, 0);
    for (int i = 0; i < SLOTS; i++) send_item(OP_CLEAR, 0, 0, i, 1'b0);
    write_reg(CFG_PROXIMITY, 0);
    write_reg(CFG_REVISIT, 0);
    write_reg(CFG_UNVISITED, 0);
    write_reg(CFG_GUIDANCE, 0);
    write_reg(CFG_BACKTRACK, 0);
    choose_at(0, 0);
  endtask

  task automatic test_backpressure();
    // receiver holds off while chooses keep coming; the input stalls
    write_reg(CFG_GRID_WIDTH, 3);
    write_reg(CFG_GRID_HEIGHT, 3);
    stall_req = 1'b1;
    no_gaps = 1'b1;
    repeat (5) choose_at($urandom_range(0, 2), $urandom_range(0, 2));
    no_gaps = 1'b0;
  endtask

  task automatic random_settings();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      write_reg(CFG_GRID_WIDTH, $urandom_range(0, 1) ? 64 : 127);
      write_reg(CFG_GRID_HEIGHT, $urandom_range(1, 4));
    end else begin
      write_reg(CFG_GRID_WIDTH, $urandom_range(1, 8));
      write_reg(CFG_GRID_HEIGHT, $urandom_range(1, 8));
    end
    write_reg(CFG_WALLS_EN, $urandom_range(0, 3) != 0);
    write_reg(CFG_UNVISITED, $urandom_range(0, 1023));
    write_reg(CFG_REVISIT, $urandom_range(0, 60));
    write_reg(CFG_PROXIMITY, $urandom_range(0, 1023));
    write_reg(CFG_GUIDANCE, $urandom_range(0, 1023));
    write_reg(CFG_BACKTRACK, $urandom_range(0, 1023));
  endtask

  task automatic test_random();
    int r, lim_x, lim_y;
    for (int n = 0; n < 48; ) begin
      if (n % 12 == 0) begin
        random_settings();
        phases++;
        no_gaps = (phases % 4 == 3);
        walk_x = $urandom_range(0, 7);
        walk_y = $urandom_range(0, 7);
      end
      lim_x = eff(grid_w) > 0 ? eff(grid_w) - 1 : 0;
      lim_y = eff(grid_h) > 0 ? eff(grid_h) - 1 : 0;
      r = $urandom_range(0, 19);
      if (r < 3)
        send_item(OP_WALL, $urandom_range(0, lim_x), $urandom_range(0, lim_y),
                  $urandom_range(0, 15), $urandom_range(0, 1));
      else if (r < 5)
        send_item(OP_PLACE, $urandom_range(0, lim_x + 2), $urandom_range(0, lim_y + 2),
                  $urandom_range(0, 15), $urandom_range(0, 1));
      else if (r < 6)
        send_item(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 15), $urandom_range(0, 1));
      else if (r < 7)
        send_item(opcode_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                  $urandom_range(0, 63), $urandom_range(0, 15), $urandom_range(0, 1));
      else
        choose_at(walk_x, walk_y);
      n++;
    end
    no_gaps = 1'b0;
  endtask

  // ---------------- sequence ----------------
  initial begin : main_seq
    grid_w = 64; grid_h = 64; walls_on = 1;
    bonus_new = 100; pen_revisit = 10; pen_near = 50; bonus_guide = 30; pen_back = 20;
    for (int i = 0; i < CELLS; i++) begin
      wall_cell[i] = 1'b0;
      visits[i] = 0;
      parent[i] = 0;
      bfs_queue[i] = 0;
    end
    for (int i = 0; i < SLOTS; i++) agent_tab[i] = '0;
    last_x = 0; last_y = 0; last_ok = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_all_blocked();
    test_walls_agents();
    test_saturation();
    test_backpressure();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d input beats, %0d move choices, %0d results, %0d random phases",
             items_sent, chooses, results_seen, phases);
    $display("register extremes, blocked and saturated scores and a long output stall included");
    if (errors == 0) begin
      $display("tb_grid_explorer_move_selector_unit: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_grid_explorer_move_selector_unit: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #40_000_000;
    $display("timeout with %0d results outstanding", pending_moves.size());
    $display("tb_grid_explorer_move_selector_unit: FAIL");
    $finish;
  end

endmodule
